// File: sv/edit_distance_engine_defines.svh
`ifndef EDIT_DISTANCE_ENGINE_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EDE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define EDE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ede_pkg.sv
`default_nettype none

package ede_pkg;

  localparam int MAX_LEN_DEF = 256;
  localparam int LEN_W_DEF   = $clog2(MAX_LEN_DEF + 1);

  localparam int MODE_W = 2;
  localparam int SYM_W  = 8;
  localparam int DIST_W = 9;

  localparam int DIST_MAX = 511;

  localparam logic [MODE_W-1:0] MODE_FIRST   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SECOND  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

endpackage

`default_nettype wire

// File: sv/ede_if.sv
`default_nettype none

interface ede_in_if import ede_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SYM_W-1:0]  symbol;

  modport source (output valid, output mode, output symbol, input ready);
  modport sink   (input valid, input mode, input symbol, output ready);
endinterface

interface ede_out_if import ede_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              status;

  modport source (output valid, output distance, output status, input ready);
  modport sink   (input valid, input distance, input status, output ready);
endinterface

`default_nettype wire

// File: sv/ede_cell.sv
`default_nettype none

module ede_cell import ede_pkg::*; #(
  parameter int W = LEN_W_DEF
) (
  input  logic [W-1:0]     diag,
  input  logic [W-1:0]     left,
  input  logic [W-1:0]     above,
  input  logic [SYM_W-1:0] a_sym,
  input  logic [SYM_W-1:0] b_sym,
  output logic [W-1:0]     value
);

  logic [W:0] sub_cost;
  logic [W:0] ins_cost;
  logic [W:0] del_cost;
  logic [W:0] best;

  always_comb begin
    sub_cost = {1'b0, diag} + (W+1)'(a_sym != b_sym);
    ins_cost = {1'b0, left} + (W+1)'(1);
    del_cost = {1'b0, above} + (W+1)'(1);
    best = (sub_cost < ins_cost) ? sub_cost : ins_cost;
    if (del_cost < best) begin
      best = del_cost;
    end
    // a cell never exceeds the longer sequence length, so it fits W bits
    value = best[W-1:0];
  end

endmodule

`default_nettype wire

// File: sv/edit_distance_engine.sv
// load items: one per cycle, no result
// compute item: an init pass over the single row memory, then per row a row-start step
// and a step per cell, then the done step; with an empty sequence only the done step
// no new item is taken during a compute walk; a result waits in the output register
// reset (rst, synchronous): lengths, overflow flag, sequencer and output valid cleared;
// the symbol and row memories are not cleared and need no clearing pass
`default_nettype none
`include "edit_distance_engine_defines.svh"

module edit_distance_engine import ede_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ede_in_if.sink      req,
  ede_out_if.source   rsp
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int XW = (LW > DIST_W) ? LW : DIST_W;

  typedef enum logic [2:0] {S_IDLE, S_INIT, S_ROW, S_CELL, S_DONE} state_t;

  state_t state;

  logic [LW-1:0] first_length;
  logic [LW-1:0] second_length;
  logic          overflow_flag;
  logic [LW-1:0] i_cnt;
  logic [LW-1:0] j_cnt;
  logic [LW-1:0] left_val;
  logic [LW-1:0] diag_val;
  logic [LW-1:0] result;

  logic              out_valid;
  logic [DIST_W-1:0] out_distance;
  logic              out_status;

  logic [SYM_W-1:0] first_mem  [MAX_LEN];
  logic [SYM_W-1:0] second_mem [MAX_LEN];
  logic [LW-1:0]    row_mem    [MAX_LEN];

  logic [SYM_W-1:0] a_sym;
  logic [SYM_W-1:0] b_sym;
  logic [LW-1:0]    above_val;

  logic          req_fire;
  logic          first_full;
  logic          second_full;
  logic          first_we;
  logic          second_we;
  logic          first_re;
  logic          col_re;
  logic [AW-1:0] col_raddr;
  logic [LW-1:0] i_m1;
  logic [LW-1:0] j_m1;
  logic          row_we;
  logic [LW-1:0] row_wdata;
  logic [LW-1:0] cell_val;
  logic          out_free;
  logic [XW-1:0] result_x;
  logic [DIST_W-1:0] dist_sat;

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.distance = out_distance;
  assign rsp.status   = out_status;

  always_comb begin
    req_fire    = req.valid && req.ready;
    first_full  = (first_length == LW'(MAX_LEN));
    second_full = (second_length == LW'(MAX_LEN));
    first_we    = req_fire && (req.mode == MODE_FIRST) && !first_full;
    second_we   = req_fire && (req.mode == MODE_SECOND) && !second_full;
    i_m1        = i_cnt - LW'(1);
    j_m1        = j_cnt - LW'(1);
    first_re    = (state == S_ROW);
    // read column j+1 while cell j is being written
    col_re      = (state == S_ROW) || ((state == S_CELL) && (j_cnt != second_length));
    col_raddr   = (state == S_ROW) ? '0 : j_cnt[AW-1:0];
    row_we      = (state == S_INIT) || (state == S_CELL);
    row_wdata   = (state == S_INIT) ? j_cnt : cell_val;
    out_free    = !out_valid || rsp.ready;
    result_x    = XW'(result);
    dist_sat    = (result_x > XW'(DIST_MAX)) ? DIST_W'(DIST_MAX) : result_x[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (first_we) begin
      first_mem[first_length[AW-1:0]] <= req.symbol;
    end
    if (first_re) begin
      a_sym <= first_mem[i_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (second_we) begin
      second_mem[second_length[AW-1:0]] <= req.symbol;
    end
    if (col_re) begin
      b_sym <= second_mem[col_raddr];
    end
  end

  // a row-start step parts rows, so a row's last write lands before the next row reads it
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[j_m1[AW-1:0]] <= row_wdata;
    end
    if (col_re) begin
      above_val <= row_mem[col_raddr];
    end
  end

  ede_cell #(.W(LW)) u_cell (
    .diag  (diag_val),
    .left  (left_val),
    .above (above_val),
    .a_sym (a_sym),
    .b_sym (b_sym),
    .value (cell_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_length  <= '0;
      second_length <= '0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // the done step reloads the output register itself
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            case (req.mode)
              MODE_FIRST: begin
                if (first_full) begin
                  overflow_flag <= 1'b1;
                end else begin
                  first_length <= first_length + LW'(1);
                end
              end
              MODE_SECOND: begin
                if (second_full) begin
                  overflow_flag <= 1'b1;
                end else begin
                  second_length <= second_length + LW'(1);
                end
              end
              MODE_COMPUTE: begin
                if (first_length == '0 || second_length == '0) begin
                  // empty sequence: distance is the other length
                  result <= (first_length == '0) ? second_length : first_length;
                  state  <= S_DONE;
                end else begin
                  j_cnt <= LW'(1);
                  state <= S_INIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_INIT: begin
          if (j_cnt == second_length) begin
            i_cnt <= LW'(1);
            state <= S_ROW;
          end else begin
            j_cnt <= j_cnt + LW'(1);
          end
        end
        S_ROW: begin
          left_val <= i_cnt;
          diag_val <= i_m1;
          j_cnt    <= LW'(1);
          state    <= S_CELL;
        end
        S_CELL: begin
          left_val <= cell_val;
          diag_val <= above_val;
          if (j_cnt == second_length) begin
            if (i_cnt == first_length) begin
              result <= cell_val;
              state  <= S_DONE;
            end else begin
              i_cnt <= i_cnt + LW'(1);
              state <= S_ROW;
            end
          end else begin
            j_cnt <= j_cnt + LW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_distance  <= dist_sat;
            out_status    <= overflow_flag;
            first_length  <= '0;
            second_length <= '0;
            overflow_flag <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `EDE_ASSERT_NEXT(a_compute_busy, req_fire && (req.mode == MODE_COMPUTE), state != S_IDLE, "compute transfer left the sequencer idle")
  `EDE_ASSERT_NOW(a_cell_range, state == S_CELL, (j_cnt >= LW'(1)) && (j_cnt <= second_length) && (i_cnt <= first_length), "cell index outside the loaded lengths")
  `EDE_ASSERT_NOW(a_len_cap, 1'b1, (first_length <= LW'(MAX_LEN)) && (second_length <= LW'(MAX_LEN)), "sequence length above capacity")
  `EDE_ASSERT_NEXT(a_result_src, !out_valid || rsp.ready, !out_valid || ($past(state) == S_DONE), "result loaded outside the done step")

endmodule

`default_nettype wire
